[rtl/wbwi_pkg.sv]
// ----------------------------------------------------------------------------
// wbwi_pkg
// Shared constants and types for the windowed Bloom write index.
// ----------------------------------------------------------------------------
package wbwi_pkg;

    localparam int FILTER_COUNT     = 4;
    localparam int WORDS_PER_FILTER = 64;
    localparam int NUM_PROBES       = 3;

    localparam int FIDX_W    = $clog2(FILTER_COUNT);
    localparam int WORD_W    = $clog2(WORDS_PER_FILTER);
    localparam int BIT_W     = 6;
    localparam int POS_W     = WORD_W + BIT_W;
    localparam int ADDR_W    = FIDX_W + WORD_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROBE_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [63:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2   = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] ALL_ONES = 64'hffffffffffffffff;

    typedef logic [POS_W-1:0] pos_t;
    typedef pos_t [NUM_PROBES-1:0] probe_set_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_START_SEQ  = 1'b1
    } cfg_reg_t;

endpackage

[rtl/wbwi_mix.sv]
// ----------------------------------------------------------------------------
// wbwi_mix
// Two rounds of the 64-bit mixer on one shared 32x32 multiplier; yields the
// three probe bit positions of a key (double hashing).
// ----------------------------------------------------------------------------
module wbwi_mix import wbwi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output probe_set_t  probes
);

    localparam int SH_PRE = 30;
    localparam int SH_MID = 27;
    localparam int SH_END = 31;

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  round_reg;
    logic [1:0]  phase_reg;
    logic [63:0] v_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    pos_t        base_reg;
    probe_set_t  probes_reg;

    logic [63:0] coef;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod_c;
    logic [63:0] sum_c;
    logic [63:0] fin_mid;
    logic [63:0] fin_end;
    logic [63:0] seed;
    pos_t        step_pos;

    assign coef     = round_reg[0] ? MIX_C2 : MIX_C1;
    assign op_a     = (phase_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
    assign op_b     = (phase_reg == 2'd1) ? coef[63:32] : coef[31:0];
    assign prod_c   = {32'd0, op_a} * {32'd0, op_b};
    assign sum_c    = acc_reg + {prod_reg[31:0], 32'd0};
    assign fin_mid  = sum_c ^ (sum_c >> SH_MID);
    assign fin_end  = sum_c ^ (sum_c >> SH_END);
    assign seed     = fin_end ^ GOLDEN;
    assign step_pos = fin_end[POS_W-1:0] | pos_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= 2'd0;
            phase_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                round_reg <= 2'd0;
                phase_reg <= 2'd0;
                v_reg     <= key ^ (key >> SH_PRE);
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 2'd1;
                unique case (phase_reg)
                    2'd0: begin
                        prod_reg <= prod_c;
                    end
                    2'd1: begin
                        acc_reg  <= prod_reg;
                        prod_reg <= prod_c;
                    end
                    2'd2: begin
                        acc_reg  <= sum_c;
                        prod_reg <= prod_c;
                    end
                    default: begin
                        round_reg <= round_reg + 2'd1;
                        unique case (round_reg)
                            2'd1: begin
                                base_reg <= fin_end[POS_W-1:0];
                                v_reg    <= seed ^ (seed >> SH_PRE);
                            end
                            2'd3: begin
                                busy_reg      <= 1'b0;
                                done_reg      <= 1'b1;
                                probes_reg[0] <= base_reg;
                                probes_reg[1] <= base_reg + step_pos;
                                probes_reg[2] <= base_reg + (step_pos << 1);
                            end
                            default: begin
                                v_reg <= fin_mid;
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign probes = probes_reg;

endmodule

[rtl/wbwi_rem.sv]
// ----------------------------------------------------------------------------
// wbwi_rem
// Restoring 64-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wbwi_rem import wbwi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] rem
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;

    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {rem_reg, num_reg[63]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= 64'd0;
            end else if (busy_reg) begin
                rem_reg <= diff[64] ? trial[63:0] : diff[63:0];
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/windowed_bloom_write_index.sv]
// Query: hash the key, then read each filter newer than the snapshot once per probe.
// Flow: one word at a time; a publish hashes, scans the filters and sets its three probe bits,
//   plus the window remainder and the open and wipe of a filter on activation.
//   The shared hash multiplier and the single filter memory port set the pace.
// Reset: synchronous, active low; all filters inactive, no memory clearing pass.
// ----------------------------------------------------------------------------
// windowed_bloom_write_index
// Rotating set of Bloom filters over windows of commit sequence numbers.
// Publish sets three probe bits in the window's filter; query reports
// whether a key is proven unchanged since a snapshot.
// ----------------------------------------------------------------------------
module windowed_bloom_write_index import wbwi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [63:0]          s_key_hash,
    input  logic [63:0]          s_seq,
    input  logic                 s_key_valid,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_proven_unchanged
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_HASH   = 11'b000_0000_0010,
        ST_SCAN   = 11'b000_0000_0100,
        ST_DIV    = 11'b000_0000_1000,
        ST_OPEN   = 11'b000_0001_0000,
        ST_WIPE   = 11'b000_0010_0000,
        ST_SRD    = 11'b000_0100_0000,
        ST_SWR    = 11'b000_1000_0000,
        ST_QRD    = 11'b001_0000_0000,
        ST_QCHK   = 11'b010_0000_0000,
        ST_RESULT = 11'b100_0000_0000
    } state_t;

    localparam logic [FIDX_W-1:0]  FIDX_LAST  = FIDX_W'(FILTER_COUNT - 1);
    localparam logic [WORD_W-1:0]  WORD_LAST  = WORD_W'(WORDS_PER_FILTER - 1);
    localparam logic [PROBE_W-1:0] PROBE_LAST = PROBE_W'(NUM_PROBES - 1);

    state_t state_reg, state_next;

    // configuration and global window state
    logic [63:0] window_len_reg;
    logic [63:0] start_seq_reg;
    logic [63:0] coverage_reg;
    logic [63:0] latest_reg;

    // per-filter bookkeeping
    logic [FILTER_COUNT-1:0] active_reg;
    logic [63:0]             wfirst_reg [FILTER_COUNT];
    logic [63:0]             wlast_reg  [FILTER_COUNT];
    logic [63:0]             pub_reg    [FILTER_COUNT];

    // latched request
    logic        req_type_reg;
    logic        key_valid_reg;
    logic [63:0] seq_reg;

    // scan / sequencing
    logic [FIDX_W-1:0]  scan_f_reg;
    logic               found_reg;
    logic [FIDX_W-1:0]  sel_reg;
    logic               free_found_reg;
    logic [FIDX_W-1:0]  free_idx_reg;
    logic [FIDX_W-1:0]  min_idx_reg;
    logic [63:0]        min_first_reg;
    logic [63:0]        min_last_reg;
    logic [63:0]        first_reg;
    logic [WORD_W-1:0]  wipe_reg;
    logic [PROBE_W-1:0] probe_reg;
    logic [FIDX_W-1:0]  qf_reg;
    logic               ok_reg;
    logic               hit_acc_reg;
    logic               m_valid_reg;
    logic               m_proven_reg;

    // filter memory
    logic [63:0]       mem [MEM_DEPTH];
    logic [63:0]       rdata_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [63:0]       mem_wdata;

    // hash and remainder units
    logic        mix_start;
    logic        mix_done;
    probe_set_t  probes;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_rem;

    // helpers
    logic [63:0]       eff_len;
    logic [63:0]       anchor;
    logic [64:0]       last_sum;
    logic [63:0]       win_last_c;
    logic              scan_last;
    logic              in_win;
    logic              found_c;
    logic              free_c;
    logic [FIDX_W-1:0] target;
    pos_t              cur_pos;
    logic              q_elig;
    logic              q_last;
    logic              rd_bit;
    logic              q_hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign mix_start = s_valid && s_ready;

    assign eff_len    = (window_len_reg == 64'd0) ? 64'd1 : window_len_reg;
    assign anchor     = (&start_seq_reg) ? start_seq_reg : start_seq_reg + 64'd1;
    assign last_sum   = {1'b0, first_reg} + {1'b0, eff_len - 64'd1};
    // saturate the window end at all ones
    assign win_last_c = last_sum[64] ? ALL_ONES : last_sum[63:0];

    assign scan_last = (scan_f_reg == FIDX_LAST);
    assign in_win    = active_reg[scan_f_reg] && (seq_reg >= wfirst_reg[scan_f_reg])
                       && (seq_reg <= wlast_reg[scan_f_reg]);
    assign found_c   = found_reg || in_win;
    assign free_c    = !active_reg[scan_f_reg] && !free_found_reg;
    // prefer a free filter, else recycle the oldest window
    assign target    = free_found_reg ? free_idx_reg : min_idx_reg;

    assign cur_pos = probes[probe_reg];
    assign q_elig  = active_reg[qf_reg] && (pub_reg[qf_reg] > seq_reg);
    assign q_last  = (qf_reg == FIDX_LAST);
    assign rd_bit  = rdata_reg[cur_pos[BIT_W-1:0]];
    assign q_hit   = hit_acc_reg && rd_bit;

    assign div_start = (state_reg == ST_SCAN) && scan_last && !found_c
                       && (seq_reg > anchor);

    wbwi_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .key     (s_key_hash),
        .done    (mix_done),
        .probes  (probes)
    );

    wbwi_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (seq_reg - anchor),
        .den     (eff_len),
        .done    (div_done),
        .rem     (div_rem)
    );

    // ---- filter memory port: wipe, bit set read-modify-write, query reads
    always_comb begin
        priority if (state_reg == ST_WIPE) begin
            mem_addr = {sel_reg, wipe_reg};
        end else if (state_reg == ST_QRD) begin
            mem_addr = {qf_reg, cur_pos[POS_W-1:BIT_W]};
        end else begin
            mem_addr = {sel_reg, cur_pos[POS_W-1:BIT_W]};
        end
    end

    assign mem_we    = (state_reg == ST_WIPE) || (state_reg == ST_SWR);
    assign mem_wdata = (state_reg == ST_WIPE) ? 64'd0
                       : (rdata_reg | (64'd1 << cur_pos[BIT_W-1:0]));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // ---- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_HASH;
            end
            ST_HASH: begin
                if (mix_done) begin
                    priority if (req_type_reg) begin
                        state_next = ST_QRD;
                    end else if (key_valid_reg && seq_reg != 64'd0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    priority if (found_c) begin
                        state_next = ST_SRD;
                    end else if (seq_reg <= anchor) begin
                        state_next = ST_OPEN;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OPEN;
            end
            ST_OPEN: begin
                state_next = ST_WIPE;
            end
            ST_WIPE: begin
                if (wipe_reg == WORD_LAST) state_next = ST_SRD;
            end
            ST_SRD: begin
                state_next = ST_SWR;
            end
            ST_SWR: begin
                state_next = (probe_reg == PROBE_LAST) ? ST_IDLE : ST_SRD;
            end
            ST_QRD: begin
                priority if (!ok_reg) begin
                    state_next = ST_RESULT;
                end else if (q_elig) begin
                    state_next = ST_QCHK;
                end else if (q_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_QCHK: begin
                if (probe_reg == PROBE_LAST && (q_hit || q_last)) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_QRD;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_len_reg <= 64'd1;
            start_seq_reg  <= 64'd0;
            coverage_reg   <= 64'd0;
            latest_reg     <= 64'd0;
            active_reg     <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            ok_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    // hold the request word while the hash runs
                    if (s_valid) begin
                        req_type_reg  <= s_req_type;
                        key_valid_reg <= s_key_valid;
                        seq_reg       <= s_seq;
                    end
                end
                ST_HASH: begin
                    if (mix_done) begin
                        ok_reg      <= key_valid_reg && (seq_reg >= coverage_reg);
                        qf_reg      <= '0;
                        probe_reg   <= '0;
                        hit_acc_reg <= 1'b1;
                        scan_f_reg     <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        // out-of-order publish: drop every filter
                        if (!req_type_reg && key_valid_reg && seq_reg != 64'd0
                            && seq_reg < coverage_reg) begin
                            active_reg   <= '0;
                            coverage_reg <= latest_reg;
                        end
                    end
                end
                ST_SCAN: begin
                    scan_f_reg <= scan_f_reg + FIDX_W'(1);
                    found_reg  <= found_c;
                    probe_reg  <= '0;
                    if (in_win && !found_reg) sel_reg <= scan_f_reg;
                    if (free_c) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_f_reg;
                    end
                    if (scan_f_reg == '0 || wfirst_reg[scan_f_reg] < min_first_reg) begin
                        min_idx_reg   <= scan_f_reg;
                        min_first_reg <= wfirst_reg[scan_f_reg];
                        min_last_reg  <= wlast_reg[scan_f_reg];
                    end
                    if (scan_last && !found_c && seq_reg <= anchor) begin
                        first_reg <= anchor;
                    end
                end
                ST_DIV: begin
                    // window start = seq minus its offset into the window
                    if (div_done) first_reg <= seq_reg - div_rem;
                end
                ST_OPEN: begin
                    active_reg[target] <= 1'b1;
                    sel_reg            <= target;
                    wipe_reg           <= '0;
                    if (!free_found_reg && min_last_reg > coverage_reg) begin
                        coverage_reg <= min_last_reg;
                    end
                end
                ST_WIPE: begin
                    wipe_reg <= wipe_reg + WORD_W'(1);
                end
                ST_SRD: begin
                end
                ST_SWR: begin
                    if (probe_reg == PROBE_LAST) begin
                        if (seq_reg > latest_reg) latest_reg <= seq_reg;
                    end else begin
                        probe_reg <= probe_reg + PROBE_W'(1);
                    end
                end
                ST_QRD: begin
                    if (ok_reg && !q_elig && !q_last) qf_reg <= qf_reg + FIDX_W'(1);
                end
                ST_QCHK: begin
                    if (probe_reg == PROBE_LAST) begin
                        if (q_hit) ok_reg <= 1'b0;
                        qf_reg      <= qf_reg + FIDX_W'(1);
                        probe_reg   <= '0;
                        hit_acc_reg <= 1'b1;
                    end else begin
                        hit_acc_reg <= q_hit;
                        probe_reg   <= probe_reg + PROBE_W'(1);
                    end
                end
                ST_RESULT: begin
                end
                default: begin
                end
            endcase
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_LEN: begin
                        window_len_reg <= cfg_data;
                    end
                    REG_START_SEQ: begin
                        start_seq_reg <= cfg_data;
                        coverage_reg  <= cfg_data;
                        latest_reg    <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // window bookkeeping, written on activation and with the last probe bit write
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OPEN) begin
            wfirst_reg[target] <= first_reg;
            wlast_reg[target]  <= win_last_c;
            pub_reg[target]    <= (first_reg == 64'd0) ? 64'd0 : first_reg - 64'd1;
        end else if (state_reg == ST_SWR && probe_reg == PROBE_LAST
                     && seq_reg > pub_reg[sel_reg]) begin
            pub_reg[sel_reg] <= seq_reg;
        end
    end

    // output register: result may wait here while the next word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_RESULT && (!m_valid_reg || m_ready)) begin
            m_valid_reg  <= 1'b1;
            m_proven_reg <= ok_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_proven_unchanged = m_proven_reg;

`ifndef SYNTHESIS
    a_mem_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_WIPE || state_reg == ST_SWR))
        else $error("filter memory written outside wipe or bit set");

    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RESULT))
        else $error("result raised without a finished query");

    a_mix_done_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_done |-> state_reg == ST_HASH)
        else $error("hash finished outside hash state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("remainder finished outside divide state");
`endif

endmodule

[dv/windowed_bloom_write_index_chk.sv]
// ----------------------------------------------------------------------------
// windowed_bloom_write_index_chk
// Watches the config, request and result channels, keeps a shadow of the
// filter set and compares every query answer with its prediction.
// ----------------------------------------------------------------------------
module windowed_bloom_write_index_chk import wbwi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [63:0]          s_key_hash,
    input  logic [63:0]          s_seq,
    input  logic                 s_key_valid,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_proven_unchanged,
    output int                   fail_count,
    output int                   answers_pending
);

    localparam int POS_BITS = WORDS_PER_FILTER * 64;

    logic [63:0] win_len_q, start_q;
    logic [POS_BITS-1:0] bloom [FILTER_COUNT];
    logic        active [FILTER_COUNT];
    logic [63:0] win_first [FILTER_COUNT];
    logic [63:0] win_last  [FILTER_COUNT];
    logic [63:0] pub_upto  [FILTER_COUNT];
    logic [63:0] cov_start, latest_pub;
    bit          answer_q [$];

    function automatic logic [63:0] splitmix(logic [63:0] v);
        v = v ^ (v >> 30);
        v = v * MIX_C1;
        v = v ^ (v >> 27);
        v = v * MIX_C2;
        return v ^ (v >> 31);
    endfunction

    function automatic logic [63:0] eff_len();
        return (win_len_q == 0) ? 64'd1 : win_len_q;
    endfunction

    function automatic logic [63:0] aligned_start(logic [63:0] s);
        logic [63:0] a, len, q;
        a = (start_q == ALL_ONES) ? start_q : start_q + 1;
        len = eff_len();
        if (s <= a) return a;
        q = (s - a) / len;
        if (q > (ALL_ONES - a) / len) return ALL_ONES;
        return a + q * len;
    endfunction

    function automatic void open_filter(int f, logic [63:0] first);
        logic [63:0] len;
        len = eff_len();
        bloom[f] = '0;
        win_first[f] = first;
        win_last[f] = ((ALL_ONES - first) < len - 1) ? ALL_ONES : first + len - 1;
        pub_upto[f] = (first == 0) ? 64'd0 : first - 1;
        active[f] = 1'b1;
    endfunction

    // Apply one accepted request; return 1 and the answer for a query.
    function automatic bit apply_request(bit is_query, logic [63:0] key,
                                         logic [63:0] s, bit kv, output bit ans);
        logic [63:0] base, step;
        int pos [3];
        int sel, oldest;
        bit hit;
        base = splitmix(key);
        step = splitmix(base ^ GOLDEN) | 64'd1;
        for (int p = 0; p < 3; p++)
            pos[p] = int'((base + 64'(p) * step) & 64'(POS_BITS - 1));
        if (is_query) begin
            ans = kv && (s >= cov_start);
            for (int f = 0; ans && f < FILTER_COUNT; f++) begin
                if (!active[f] || pub_upto[f] <= s) continue;
                hit = 1'b1;
                for (int p = 0; p < 3; p++)
                    if (!bloom[f][pos[p]]) hit = 1'b0;
                if (hit) ans = 1'b0;
            end
            return 1'b1;
        end
        ans = 1'b0;
        if (!kv || s == 0) return 1'b0;
        // Out-of-order publish: drop every filter.
        if (s < cov_start) begin
            for (int f = 0; f < FILTER_COUNT; f++) begin
                bloom[f] = '0;
                active[f] = 1'b0;
            end
            cov_start = latest_pub;
        end
        sel = -1;
        for (int f = 0; f < FILTER_COUNT; f++)
            if (sel < 0 && active[f] && s >= win_first[f] && s <= win_last[f]) sel = f;
        if (sel < 0) begin
            for (int f = 0; f < FILTER_COUNT; f++)
                if (sel < 0 && !active[f]) sel = f;
            if (sel < 0) begin
                oldest = 0;
                for (int f = 1; f < FILTER_COUNT; f++)
                    if (win_first[f] < win_first[oldest]) oldest = f;
                if (win_last[oldest] > cov_start) cov_start = win_last[oldest];
                sel = oldest;
            end
            open_filter(sel, aligned_start(s));
        end
        for (int p = 0; p < 3; p++) bloom[sel][pos[p]] = 1'b1;
        if (s > pub_upto[sel]) pub_upto[sel] = s;
        if (s > latest_pub) latest_pub = s;
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        bit ans, got;
        if (!aresetn) begin
            win_len_q  = 64'd1;
            start_q    = 64'd0;
            cov_start  = 64'd0;
            latest_pub = 64'd0;
            fail_count = 0;
            for (int f = 0; f < FILTER_COUNT; f++) begin
                bloom[f] = '0;
                active[f] = 1'b0;
                win_first[f] = 0;
                win_last[f] = 0;
                pub_upto[f] = 0;
            end
            answer_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_reg_t'(cfg_index) == REG_WINDOW_LEN) begin
                    win_len_q = cfg_data;
                end else begin
                    start_q = cfg_data;
                    cov_start = cfg_data;
                    latest_pub = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result word, proven_unchanged=%0b",
                           m_proven_unchanged);
                    fail_count++;
                end else begin
                    got = answer_q.pop_front();
                    if (m_proven_unchanged !== got) begin
                        $error("proven_unchanged: expected %0b actual %0b",
                               got, m_proven_unchanged);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (apply_request(s_req_type, s_key_hash, s_seq, s_key_valid, ans))
                    answer_q.push_back(ans);
            end
        end
        answers_pending = answer_q.size();
    end

endmodule

[dv/windowed_bloom_write_index_tb.sv]
// ----------------------------------------------------------------------------
// windowed_bloom_write_index_tb
// Drives configuration phases and publish/query traffic into the write index
// with random idling on both channels; the checker predicts every answer.
// ----------------------------------------------------------------------------
module windowed_bloom_write_index_tb;
    import wbwi_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = 1'b0;
    logic [63:0]          s_key_hash = '0;
    logic [63:0]          s_seq = '0;
    logic                 s_key_valid = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_proven_unchanged;
    int                   fail_count;
    int                   answers_pending;

    // idle rates in percent for the two sides
    int send_idle_pct = 37;
    int recv_idle_pct = 78;

    // recently published keys, reused so queries can hit, and the sequence frontier
    logic [63:0] recent_keys [$];
    logic [63:0] seq_cursor;

    always #5 aclk = ~aclk;

    windowed_bloom_write_index i_dut (.*);

    windowed_bloom_write_index_chk i_chk (.*);

    // Receiver: stall at random, re-decide every cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send one request word; hold it until accepted, then maybe idle.
    task automatic send_word(bit is_query, logic [63:0] key, logic [63:0] s, bit kv);
        s_valid     <= 1'b1;
        s_req_type  <= is_query;
        s_key_hash  <= key;
        s_seq       <= s;
        s_key_valid <= kv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!is_query && kv) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 16) void'(recent_keys.pop_front());
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Wait until every answer is in, then let a publish finish its wipe.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (recent_keys.size() != 0 && $urandom_range(99) < 60)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        return rand64();
    endfunction

    // Mostly ordered publishes interleaved with queries around the frontier.
    task automatic random_phase(int n, logic [63:0] step_max);
        logic [63:0] q;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    seq_cursor = seq_cursor + 64'($urandom_range(int'(step_max)));
                    send_word(1'b0, pick_key(), seq_cursor, $urandom_range(19) != 0);
                end
                4, 5, 6, 7: begin
                    q = seq_cursor - 64'($urandom_range(int'(step_max) * 6));
                    send_word(1'b1, pick_key(), q, $urandom_range(15) != 0);
                end
                8: send_word(1'b0, pick_key(), seq_cursor - 64'($urandom_range(40)),
                             $urandom_range(1) != 0);
                default: send_word($urandom_range(1) != 0, rand64(), rand64(),
                                   $urandom_range(1) != 0);
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, invalid items, out-of-order and saturation.
        write_reg(REG_WINDOW_LEN, 64'd4);
        write_reg(REG_START_SEQ, 64'd0);
        send_word(1'b1, 64'd0, 64'd0, 1'b1);
        send_word(1'b0, 64'd0, 64'd0, 1'b1);            // seq zero: ignored
        send_word(1'b0, ALL_ONES, 64'd5, 1'b0);         // invalid key: ignored
        send_word(1'b0, 64'h1234, 64'd1, 1'b1);
        send_word(1'b1, 64'h1234, 64'd0, 1'b1);
        send_word(1'b1, 64'h1234, 64'd1, 1'b1);
        send_word(1'b1, 64'h1234, 64'd0, 1'b0);         // invalid query
        for (int k = 0; k < 6; k++)
            send_word(1'b0, 64'(k) * 64'h1111, 64'd5 + 64'(k) * 4, 1'b1);  // force recycling
        send_word(1'b1, 64'h1234, 64'd2, 1'b1);
        send_word(1'b0, 64'hdead, 64'd2, 1'b1);         // below coverage: wipe all
        send_word(1'b1, 64'hdead, 64'd1, 1'b1);
        send_word(1'b1, ALL_ONES, ALL_ONES, 1'b1);
        drain();

        write_reg(REG_WINDOW_LEN, 64'd0);
        write_reg(REG_START_SEQ, ALL_ONES);
        send_word(1'b0, ALL_ONES, ALL_ONES, 1'b1);
        send_word(1'b1, ALL_ONES, ALL_ONES, 1'b1);
        send_word(1'b1, ALL_ONES, ALL_ONES - 1, 1'b1);
        drain();

        write_reg(REG_WINDOW_LEN, ALL_ONES);
        write_reg(REG_START_SEQ, ALL_ONES - 10);
        send_word(1'b0, 64'h55, ALL_ONES - 3, 1'b1);
        send_word(1'b1, 64'h55, ALL_ONES - 9, 1'b1);
        send_word(1'b1, 64'h55, ALL_ONES, 1'b1);
        drain();

        // Random: several settings, three idling regimes.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 78;
                recv_idle_pct = 37;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_WINDOW_LEN, 64'($urandom_range(1, 12)));
            seq_cursor = (ph == 5) ? ALL_ONES - 2000 : 64'($urandom_range(0, 1000));
            write_reg(REG_START_SEQ, seq_cursor);
            recent_keys.delete();
            random_phase(140, 64'd5);
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/wbwi_pkg.sv
rtl/wbwi_mix.sv
rtl/wbwi_rem.sv
rtl/windowed_bloom_write_index.sv
dv/windowed_bloom_write_index_chk.sv
dv/windowed_bloom_write_index_tb.sv
